@@ src/ptfa_pkg.sv @@
// Shared constants, types and helpers for the page table with frame allocator.
`default_nettype none

package ptfa_pkg;

  // Sizing of the table and the frame pool. PHYS_FRAMES must be a power of two:
  // the reuse frame is folded into range with a mask.
  localparam int NUM_PROCS   = 16;
  localparam int VIRT_PAGES  = 1024;
  localparam int PHYS_FRAMES = 4096;

  // Field widths fixed by the stream format.
  localparam int PID_W   = 4;
  localparam int PAGE_W  = 10;
  localparam int FRAME_W = 12;
  localparam int CNT_W   = 32;

  localparam int ENTRIES    = NUM_PROCS * VIRT_PAGES;
  localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PROC_IDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int FREE_W     = $clog2(PHYS_FRAMES + 1);

  localparam logic [FRAME_W-1:0] FRAME_MASK = FRAME_W'(PHYS_FRAMES - 1);
  localparam logic [CNT_W-1:0]   CNT_MAX    = '1;

  // Stream widths: payload packed from bit 0, padded to whole bytes.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USER_W = 2;

  // One table entry: valid flag above the frame number.
  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } pte_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } ptfa_state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ src/page_table_with_frame_allocator.sv @@
// Top level: demand-paged single-level page table with a down-counting frame allocator.
//
//   channel | direction | tdata fields (low bit up)                         | tuser
//   in_     | slave     | pid, vpage, reuse_frame                           | -
//   out_    | master    | frame, process_faults, process_accesses,          | fault,
//           |           | total_faults                                      | frames_exhausted
//
// The table is read on the edge that accepts a transaction; in the write-back state, once
// the output register can take the result, a faulting entry is written back, the counters
// advance and the result is loaded into the output register. The table has a single read
// and a single write port. After reset a clearing pass walks all ENTRIES rows, one per
// cycle (16384 rows with the default sizing); nothing is accepted until it ends. A waiting
// result does not block acceptance; only write-back waits for a full output register.
`default_nettype none

module page_table_with_frame_allocator (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // in_tdata: pid[3:0], vpage[13:4], reuse_frame[25:14], zero above
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [ptfa_pkg::IN_DATA_W-1:0]       in_tdata,
  // out_tdata: frame[11:0], process_faults[43:12], process_accesses[75:44],
  //            total_faults[107:76], zero above
  // out_tuser: fault[0], frames_exhausted[1]
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [ptfa_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [ptfa_pkg::OUT_USER_W-1:0]      out_tuser
);

  localparam int PID_W      = ptfa_pkg::PID_W;
  localparam int PAGE_W     = ptfa_pkg::PAGE_W;
  localparam int FRAME_W    = ptfa_pkg::FRAME_W;
  localparam int CNT_W      = ptfa_pkg::CNT_W;
  localparam int IDX_W      = ptfa_pkg::IDX_W;
  localparam int PROC_IDX_W = ptfa_pkg::PROC_IDX_W;
  localparam int FREE_W     = ptfa_pkg::FREE_W;

  // ---------------------------------------------------------------------------
  // Input unpacking
  // ---------------------------------------------------------------------------
  logic [PID_W-1:0]   in_pid;
  logic [PAGE_W-1:0]  in_page;
  logic [FRAME_W-1:0] in_reuse;
  logic               in_oor;
  logic [IDX_W-1:0]   in_idx;
  logic               in_accept;

  assign in_pid   = in_tdata[PID_W-1:0];
  assign in_page  = in_tdata[PID_W+PAGE_W-1:PID_W];
  assign in_reuse = in_tdata[PID_W+PAGE_W+FRAME_W-1:PID_W+PAGE_W];

  // Flag processes or pages beyond the configured table; such accesses leave the table and counters unchanged.
  assign in_oor = (int'(in_pid) >= ptfa_pkg::NUM_PROCS) ||
                  (int'(in_page) >= ptfa_pkg::VIRT_PAGES);

  // Row of this (process, page) pair: process-major layout.
  assign in_idx = IDX_W'(IDX_W'(in_pid) * IDX_W'(ptfa_pkg::VIRT_PAGES)) + IDX_W'(in_page);

  assign in_accept = in_tvalid && in_tready;

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  ptfa_pkg::ptfa_state_t state_r, state_nxt;

  logic [IDX_W-1:0]   clr_r;         // clearing pass row pointer
  logic [IDX_W-1:0]   idx_r;         // table row of the transaction in flight
  logic [PID_W-1:0]   pid_r;
  logic [FRAME_W-1:0] reuse_r;
  logic               oor_r;
  logic [FREE_W-1:0]  free_r;        // frames still free; next frame is free_r - 1

  logic [CNT_W-1:0]   acc_r [ptfa_pkg::NUM_PROCS];
  logic [CNT_W-1:0]   flt_r [ptfa_pkg::NUM_PROCS];
  logic [CNT_W-1:0]   tot_r;

  logic                            out_tvalid_r;
  logic [ptfa_pkg::OUT_DATA_W-1:0] out_tdata_r;
  logic [ptfa_pkg::OUT_USER_W-1:0] out_tuser_r;

  // Page table memory: one write port, one registered read port.
  ptfa_pkg::pte_t mem [ptfa_pkg::ENTRIES];
  ptfa_pkg::pte_t rd_data_r;

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  logic clr_done;
  logic upd_go;

  assign clr_done = (clr_r == IDX_W'(ptfa_pkg::ENTRIES - 1));
  // Write back only once the output register can take the result.
  assign upd_go   = (state_r == ptfa_pkg::ST_UPDATE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ptfa_pkg::ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = ptfa_pkg::ST_IDLE;
        end
      end
      ptfa_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ptfa_pkg::ST_UPDATE;
        end
      end
      ptfa_pkg::ST_UPDATE: begin
        if (upd_go) begin
          state_nxt = ptfa_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ptfa_pkg::ST_CLEAR;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs and update datapath
  // ---------------------------------------------------------------------------
  logic [PROC_IDX_W-1:0] pidx;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_idx;
  ptfa_pkg::pte_t        wr_data;
  logic                  do_fault;
  logic                  do_exh;
  logic [FRAME_W-1:0]    frame_sel;
  logic [CNT_W-1:0]      acc_new;
  logic [CNT_W-1:0]      flt_new;
  logic [CNT_W-1:0]      tot_new;
  logic                  commit;

  assign pidx = PROC_IDX_W'(pid_r);

  always_comb begin
    in_tready = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = idx_r;
    wr_data   = '0;
    do_fault  = 1'b0;
    do_exh    = 1'b0;
    frame_sel = '0;
    acc_new   = '0;
    flt_new   = '0;
    tot_new   = tot_r;
    commit    = 1'b0;
    case (state_r)
      ptfa_pkg::ST_CLEAR: begin
        // Drop every valid flag, one row a cycle.
        wr_en  = 1'b1;
        wr_idx = clr_r;
      end
      ptfa_pkg::ST_IDLE: begin
        in_tready = 1'b1;
      end
      ptfa_pkg::ST_UPDATE: begin
        if (!oor_r) begin
          do_fault = !rd_data_r.valid;
          if (rd_data_r.valid) begin
            frame_sel = rd_data_r.frame;
          end else if (free_r != '0) begin
            frame_sel = FRAME_W'(free_r - FREE_W'(1));
          end else begin
            do_exh    = 1'b1;
            frame_sel = reuse_r & ptfa_pkg::FRAME_MASK;
          end
          acc_new = ptfa_pkg::sat_inc(acc_r[pidx]);
          flt_new = do_fault ? ptfa_pkg::sat_inc(flt_r[pidx]) : flt_r[pidx];
          tot_new = do_fault ? ptfa_pkg::sat_inc(tot_r) : tot_r;
          commit  = upd_go;
          wr_en   = upd_go && do_fault;
          wr_data = '{valid: 1'b1, frame: frame_sel};
        end
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Page table memory
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  // Read on the accept edge so the entry is ready in the update cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      rd_data_r <= mem[in_idx];
    end
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ptfa_pkg::ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ptfa_pkg::ST_CLEAR) begin
        clr_r <= clr_r + IDX_W'(1);
      end
    end
  end

  // Hold the transaction fields for the update cycle.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      idx_r   <= in_idx;
      pid_r   <= in_pid;
      reuse_r <= in_reuse;
      oor_r   <= in_oor;
    end
  end

  // Allocator and statistics.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_r <= FREE_W'(ptfa_pkg::PHYS_FRAMES);
      tot_r  <= '0;
      for (int p = 0; p < ptfa_pkg::NUM_PROCS; p++) begin
        acc_r[p] <= '0;
        flt_r[p] <= '0;
      end
    end else if (commit) begin
      if (do_fault && !do_exh) begin
        free_r <= free_r - FREE_W'(1);
      end
      tot_r       <= tot_new;
      acc_r[pidx] <= acc_new;
      flt_r[pidx] <= flt_new;
    end
  end

  // ---------------------------------------------------------------------------
  // Output register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (upd_go) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_go) begin
      out_tdata_r <= ptfa_pkg::OUT_DATA_W'({tot_new, acc_new, flt_new, frame_sel});
      out_tuser_r <= {do_exh, do_fault};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

`ifndef SYNTHESIS
  // An accepted transaction always moves to the write-back cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ptfa_pkg::ST_UPDATE)
    else $error("accepted transaction did not enter write-back");

  // A new result appears only out of a write-back cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(state_r) == ptfa_pkg::ST_UPDATE)
    else $error("result raised outside write-back");

  // The free frame count never grows.
  assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> free_r <= $past(free_r))
    else $error("free frame count increased");

  // Exhaustion is reported only when the pool is empty and with a fault.
  assert property (@(posedge clk) disable iff (!rst_n)
    upd_go && do_exh |-> free_r == '0 && do_fault)
    else $error("exhaustion flagged with frames left");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// Self-checking testbench for the page table with frame allocator: directed table, then random.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PID_W       = ptfa_pkg::PID_W;
  localparam int PAGE_W      = ptfa_pkg::PAGE_W;
  localparam int FRAME_W     = ptfa_pkg::FRAME_W;
  localparam int CNT_W       = ptfa_pkg::CNT_W;
  localparam int FREE_W      = ptfa_pkg::FREE_W;
  localparam int ENTRIES     = ptfa_pkg::ENTRIES;
  localparam int NUM_PROCS   = ptfa_pkg::NUM_PROCS;
  localparam int PHYS_FRAMES = ptfa_pkg::PHYS_FRAMES;
  localparam int IN_DATA_W   = ptfa_pkg::IN_DATA_W;
  localparam int OUT_DATA_W  = ptfa_pkg::OUT_DATA_W;
  localparam int OUT_USER_W  = ptfa_pkg::OUT_USER_W;

  // Generous cycle budget: the clearing pass after reset, then every access with the
  // longest input gap, the longest output stall and its own processing, several times over.
  localparam int CYCLE_LIMIT  = 100000;
  localparam int RANDOM_ITEMS = 480;  // random accesses after the directed table
  localparam int CALM_TAIL    = 100;  // final accesses with no idling on either side
  localparam int DRAIN_CYCLES = 8;

  // One translation as the block reports it.
  typedef struct {
    logic [FRAME_W-1:0] frame;
    logic               fault;
    logic               exhausted;
    logic [CNT_W-1:0]   proc_faults;
    logic [CNT_W-1:0]   proc_accesses;
    logic [CNT_W-1:0]   total_faults;
  } xlat_t;

  // One row of the directed table; typed rows carry a hand-written expectation.
  typedef struct {
    logic [PID_W-1:0]   pid;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] reuse;
    bit                 typed;
    xlat_t              want;
  } access_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  page_table_with_frame_allocator uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // Shadow of the block's state: table, free-frame counter and statistics.
  bit               entry_ok [ENTRIES];
  bit [FRAME_W-1:0] entry_fr [ENTRIES];
  bit [FREE_W-1:0]  free_left = FREE_W'(PHYS_FRAMES);
  bit [CNT_W-1:0]   flt_cnt [NUM_PROCS];
  bit [CNT_W-1:0]   acc_cnt [NUM_PROCS];
  bit [CNT_W-1:0]   fault_sum;

  int    touched_idx [$];   // table rows made valid so far, for revisits
  xlat_t pending_xlat [$];  // translations accepted but not yet returned
  int    mismatches = 0;
  int    cycles = 0;
  bit    calm = 1'b0;       // set for the tail of the run: no idling at all
  int    stall_left = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block wedges.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic bit [CNT_W-1:0] bump_count(input bit [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // Advance the shadow state by one access and return the translation it yields.
  function automatic xlat_t translate(input logic [PID_W-1:0] pid,
                                      input logic [PAGE_W-1:0] page,
                                      input logic [FRAME_W-1:0] reuse);
    xlat_t r;
    int    idx;
    idx = int'({pid, page});
    r = '{default: '0};
    acc_cnt[pid] = bump_count(acc_cnt[pid]);
    if (entry_ok[idx]) begin
      r.frame = entry_fr[idx];
    end else begin
      // Page fault: take the next frame from the top of the pool, or the reuse
      // frame once the pool is empty.
      r.fault = 1'b1;
      if (free_left != 0) begin
        free_left = free_left - 1'b1;
        r.frame = free_left[FRAME_W-1:0];
      end else begin
        r.exhausted = 1'b1;
        r.frame = reuse & FRAME_W'(PHYS_FRAMES - 1);
      end
      entry_fr[idx] = r.frame;
      entry_ok[idx] = 1'b1;
      flt_cnt[pid] = bump_count(flt_cnt[pid]);
      fault_sum = bump_count(fault_sum);
      touched_idx.push_back(idx);
    end
    r.proc_faults   = flt_cnt[pid];
    r.proc_accesses = acc_cnt[pid];
    r.total_faults  = fault_sum;
    return r;
  endfunction

  function automatic access_row_t mk_row(input int pid, input int page, input int reuse,
                                         input bit typed, input int frame, input bit fault,
                                         input bit exh, input int pf, input int pa,
                                         input int tf);
    access_row_t row;
    row.pid   = PID_W'(pid);
    row.page  = PAGE_W'(page);
    row.reuse = FRAME_W'(reuse);
    row.typed = typed;
    row.want  = '{FRAME_W'(frame), fault, exh, CNT_W'(pf), CNT_W'(pa), CNT_W'(tf)};
    return row;
  endfunction

  // Offer one access, hold it until the handshake, then record what should come back.
  task automatic send_access(input logic [PID_W-1:0] pid, input logic [PAGE_W-1:0] page,
                             input logic [FRAME_W-1:0] reuse, input bit typed,
                             input xlat_t want);
    xlat_t pred;
    int    gap;
    if (!calm && $urandom_range(3) == 0) begin
      gap = $urandom_range(7, 1);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_DATA_W'({reuse, page, pid});
    do @(posedge clk); while (!in_tready);
    // Keep the shadow state in step even for rows with a typed expectation.
    pred = translate(pid, page, reuse);
    pending_xlat.push_back(typed ? want : pred);
  endtask

  // Revisit a row already mapped, or hit a random one (mostly a fresh fault).
  task automatic send_random(input int revisit_pct);
    int    idx;
    xlat_t none;
    none = '{default: '0};
    if (touched_idx.size() != 0 && $urandom_range(99) < revisit_pct) begin
      idx = touched_idx[$urandom_range(touched_idx.size() - 1)];
    end else begin
      idx = $urandom_range(ENTRIES - 1);
    end
    send_access(PID_W'(idx >> PAGE_W), PAGE_W'(idx), FRAME_W'($urandom), 1'b0, none);
  endtask

  task automatic note_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    mismatches++;
  endtask

  task automatic check_field(input string field, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want) begin
      note_mismatch($sformatf("%s got %0d, expected %0d", field, got, want));
    end
  endtask

  // Output side: random stall bursts, none in the calm tail; compare every returned
  // transaction with the oldest pending translation.
  always @(posedge clk) begin
    xlat_t want;
    if (calm) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if ($urandom_range(5) == 0) begin
      stall_left <= $urandom_range(6, 0);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end

    if (rst_n && out_tvalid && out_tready) begin
      if (pending_xlat.size() == 0) begin
        note_mismatch("result with nothing pending");
      end else begin
        want = pending_xlat.pop_front();
        check_field("frame", CNT_W'(out_tdata[11:0]), CNT_W'(want.frame));
        check_field("fault", CNT_W'(out_tuser[0]), CNT_W'(want.fault));
        check_field("frames_exhausted", CNT_W'(out_tuser[1]), CNT_W'(want.exhausted));
        check_field("process_faults", out_tdata[43:12], want.proc_faults);
        check_field("process_accesses", out_tdata[75:44], want.proc_accesses);
        check_field("total_faults", out_tdata[107:76], want.total_faults);
      end
    end
  end

  // Stimulus: directed table, then a random mix of hits and faults.
  initial begin
    access_row_t directed [$];
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;

    // Typed rows: first faults hand out frames from the top down; hits return
    // the stored frame and bump only the access count.
    directed.push_back(mk_row(0, 0, 0, 1, 4095, 1, 0, 1, 1, 1));
    directed.push_back(mk_row(0, 0, 4095, 1, 4095, 0, 0, 1, 2, 1));
    directed.push_back(mk_row(15, 1023, 4095, 1, 4094, 1, 0, 1, 1, 2));
    directed.push_back(mk_row(15, 1023, 0, 1, 4094, 0, 0, 1, 2, 2));
    directed.push_back(mk_row(0, 1023, 2048, 1, 4093, 1, 0, 2, 3, 3));
    directed.push_back(mk_row(15, 0, 1, 1, 4092, 1, 0, 2, 3, 4));
    // Alternating bit patterns and mid-range values, checked by the predictor.
    directed.push_back(mk_row(5, 'h2AA, 'hAAA, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(10, 'h155, 'h555, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(5, 'h2AA, 'h555, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(3, 512, 2048, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(12, 511, 2047, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(0, 0, 4095, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(15, 1023, 4095, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(8, 1, 1, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(7, 1022, 4094, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(10, 'h155, 0, 0, 0, 0, 0, 0, 0, 0));
    directed.push_back(mk_row(3, 512, 0, 0, 0, 0, 0, 0, 0, 0));

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // The first access waits out the clearing pass behind in_tready.
    foreach (directed[i]) begin
      send_access(directed[i].pid, directed[i].page, directed[i].reuse,
                  directed[i].typed, directed[i].want);
    end

    // Mixed hits and faults; the tail runs with no idling on either side.
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_TAIL) calm = 1'b1;
      send_random(40);
    end

    in_tvalid <= 1'b0;

    // Drain: wait for every pending translation, then idle before reporting.
    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_xlat.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
